// ===== rtl/dfs_pkg.sv =====
// Package with the payload types and constants of the depth feed sequence sync block.
package dfs_pkg;

  localparam int HOLD_DEPTH_DEF = 32;
  localparam int TAG_BITS_DEF = 16;
  localparam int ID_W = 63;
  localparam int MS_W = 43;
  localparam int LIM_W = 6;

  localparam logic [19:0] MS_TO_NS = 20'd1000000;
  localparam logic [LIM_W-1:0] LIMIT_RESET = 6'd32;

  localparam logic [1:0] FUNC_DELTA = 2'd0;
  localparam logic [1:0] FUNC_SNAPSHOT = 2'd1;
  localparam logic [1:0] FUNC_RESET = 2'd2;

  typedef struct packed {
    logic [1:0]      func;
    logic [ID_W-1:0] upd_first;
    logic [ID_W-1:0] upd_last;
    logic [ID_W-1:0] snap_id;
    logic [15:0]     payload_tag;
    logic [MS_W-1:0] event_time_ms;
    logic [ID_W-1:0] recv_time_ns;
  } in_t;

  typedef struct packed {
    logic            has_update;
    logic            snap_flag;
    logic [15:0]     out_tag;
    logic [ID_W-1:0] exchange_time_ns;
    logic [ID_W-1:0] out_recv_time_ns;
    logic            verdict;
    logic            last_of_run;
  } out_t;

endpackage

// ===== rtl/dfs_hold_mem.sv =====
// Held delta buffer: one write port, one read port with registered read data.
module dfs_hold_mem #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 185,
  parameter int AW = 5
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/dfs_ms2ns.sv =====
// Two-stage converter from milliseconds to nanoseconds.
module dfs_ms2ns (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [dfs_pkg::MS_W-1:0] ms,
  output logic                    done,
  output logic [dfs_pkg::ID_W-1:0] ns
);

  logic [41:0] p_lo_r;
  logic [40:0] p_hi_r;
  logic        v1_r;
  logic        v2_r;
  logic [dfs_pkg::ID_W-1:0] ns_r;

  // The two halves of the product are formed in the first stage.
  always_ff @(posedge clk) begin
    if (start) begin
      p_lo_r <= 42'(ms[21:0]) * 42'(dfs_pkg::MS_TO_NS);
      p_hi_r <= 41'(ms[42:22]) * 41'(dfs_pkg::MS_TO_NS);
    end
    if (v1_r) begin
      ns_r <= 63'(p_lo_r) + {p_hi_r, 22'd0};
    end
  end

  // Control bits follow the data through the two stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
    end
  end

  assign done = v2_r;
  assign ns = ns_r;

endmodule

// ===== rtl/depth_feed_sequence_sync.sv =====
// Top level of the depth feed sequence sync block: control sequencer and output register.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_ready  dfs_pkg::in_t
//   out_     output     out_valid/out_ready  dfs_pkg::out_t
//   cfg_     input      cfg_wr_en            cfg_wr_data (buffer limit)
//
// A held or rejected delta goes from idle to the emit state; a forwarded delta
// passes through the ms-to-ns multiplier in between. A snapshot scans the held
// buffer entry by entry over the single read port, then replays each surviving
// entry (read, multiply, transfer). Reset is synchronous; the buffer itself is
// not cleared, only its fill count. A stalled output holds the sequencer in place.
module depth_feed_sequence_sync #(
  parameter int HOLD_DEPTH = dfs_pkg::HOLD_DEPTH_DEF,
  parameter int TAG_BITS = dfs_pkg::TAG_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  dfs_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output dfs_pkg::out_t               out_data,
  input  logic                        cfg_wr_en,
  input  logic [dfs_pkg::LIM_W-1:0]   cfg_wr_data
);

  localparam int AW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
  localparam int CW = $clog2(HOLD_DEPTH + 1);
  localparam int IDW = dfs_pkg::ID_W;
  localparam int MSW = dfs_pkg::MS_W;
  localparam int EW = 2 * IDW + TAG_BITS + MSW;
  // Field positions inside one buffer word.
  localparam int T_LO = 0;
  localparam int G_LO = MSW;
  localparam int L_LO = MSW + TAG_BITS;
  localparam int F_LO = MSW + TAG_BITS + IDW;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_EMIT = 4'd1;
  localparam logic [3:0] S_DMUL = 4'd2;
  localparam logic [3:0] S_SCAN_RD = 4'd3;
  localparam logic [3:0] S_SCAN_CHK = 4'd4;
  localparam logic [3:0] S_SN_EMIT = 4'd5;
  localparam logic [3:0] S_RP_RD = 4'd6;
  localparam logic [3:0] S_RP_DAT = 4'd7;
  localparam logic [3:0] S_RP_MUL = 4'd8;
  localparam logic [3:0] S_RP_EMIT = 4'd9;

  logic [3:0]                state_r;
  logic [3:0]                state_nxt;
  logic [dfs_pkg::LIM_W-1:0] limit_r;
  logic [CW-1:0]             count_r;
  logic [CW-1:0]             count_nxt;
  logic [CW-1:0]             idx_r;
  logic [CW-1:0]             idx_nxt;
  logic [CW-1:0]             start_r;
  logic [CW-1:0]             start_nxt;
  logic                      skipping_r;
  logic                      skipping_nxt;
  logic [IDW-1:0]            last_id_r;
  logic [IDW-1:0]            last_id_nxt;
  logic [IDW-1:0]            through_r;
  logic [IDW-1:0]            through_nxt;
  logic                      in_sync_r;
  logic                      in_sync_nxt;
  dfs_pkg::in_t              item_r;
  dfs_pkg::in_t              item_nxt;
  dfs_pkg::out_t             res_r;
  dfs_pkg::out_t             res_nxt;
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  dfs_pkg::out_t             out_data_r;
  dfs_pkg::out_t             out_data_nxt;

  logic                      in_fire;
  logic                      can_emit;
  logic [dfs_pkg::LIM_W:0]   lim_eff;
  logic [EW-1:0]             wdata;
  logic [EW-1:0]             rdata;
  logic [IDW-1:0]            rd_first;
  logic [IDW-1:0]            rd_final;
  logic [TAG_BITS-1:0]       rd_tag;
  logic [MSW-1:0]            rd_time;
  logic [IDW:0]              next_id;
  logic [IDW:0]              through_inc;
  logic [IDW:0]              last_inc;
  logic                      mul_start;
  logic [MSW-1:0]            mul_ms;
  logic                      mul_done;
  logic [IDW-1:0]            mul_ns;
  logic [TAG_BITS-1:0]       in_tag;
  logic [TAG_BITS-1:0]       rp_tag_r;
  logic [TAG_BITS-1:0]       rp_tag_nxt;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire = in_valid && in_ready;
  assign can_emit = !out_valid_r || out_ready;
  assign in_tag = TAG_BITS'(in_data.payload_tag);

  // Effective limit is the smaller of the register and the buffer depth.
  always_comb begin
    lim_eff = {1'b0, limit_r};
    if (lim_eff > 7'(HOLD_DEPTH)) begin
      lim_eff = 7'(HOLD_DEPTH);
    end
  end

  // Buffer word and its fields.
  assign wdata = {in_data.upd_first, in_data.upd_last, in_tag, in_data.event_time_ms};
  assign rd_first = rdata[F_LO +: IDW];
  assign rd_final = rdata[L_LO +: IDW];
  assign rd_tag = rdata[G_LO +: TAG_BITS];
  assign rd_time = rdata[T_LO +: MSW];

  // Sequence arithmetic is done one bit wider so that the maximum id wraps nowhere.
  assign next_id = {1'b0, item_r.snap_id} + 64'd1;
  assign through_inc = {1'b0, through_r} + 64'd1;
  assign last_inc = {1'b0, last_id_r} + 64'd1;

  dfs_hold_mem #(
    .DEPTH(HOLD_DEPTH),
    .WIDTH(EW),
    .AW(AW)
  ) u_mem (
    .clk(clk),
    .we(in_fire && in_data.func == dfs_pkg::FUNC_DELTA && !in_sync_r
        && 7'(count_r) < lim_eff),
    .waddr(count_r[AW-1:0]),
    .wdata(wdata),
    .raddr(idx_r[AW-1:0]),
    .rdata(rdata)
  );

  // The multiplier serves both live deltas and replayed entries.
  assign mul_start = (in_fire && in_data.func == dfs_pkg::FUNC_DELTA && in_sync_r)
                     || (state_r == S_RP_DAT);
  assign mul_ms = (state_r == S_RP_DAT) ? rd_time : in_data.event_time_ms;

  dfs_ms2ns u_mul (
    .clk(clk),
    .rst_n(rst_n),
    .start(mul_start),
    .ms(mul_ms),
    .done(mul_done),
    .ns(mul_ns)
  );

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= dfs_pkg::LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  // Main sequencer. The buffer is written only on accept and read only while no
  // item can be accepted, so accesses to one entry never overlap.
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt = idx_r;
    start_nxt = start_r;
    skipping_nxt = skipping_r;
    last_id_nxt = last_id_r;
    through_nxt = through_r;
    in_sync_nxt = in_sync_r;
    item_nxt = item_r;
    res_nxt = res_r;
    rp_tag_nxt = rp_tag_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt = out_data_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          item_nxt = in_data;
          res_nxt = '0;
          res_nxt.last_of_run = 1'b1;
          state_nxt = S_EMIT;
          case (in_data.func)
            dfs_pkg::FUNC_DELTA: begin
              if (!in_sync_r) begin
                if (7'(count_r) >= lim_eff) begin
                  count_nxt = '0;
                  res_nxt.verdict = 1'b1;
                end else begin
                  count_nxt = count_r + 1'b1;
                end
              end else if ({1'b0, in_data.upd_first} != last_inc) begin
                res_nxt.verdict = 1'b1;
              end else begin
                state_nxt = S_DMUL;
              end
            end
            dfs_pkg::FUNC_SNAPSHOT: begin
              idx_nxt = '0;
              start_nxt = count_r;
              skipping_nxt = 1'b1;
              through_nxt = in_data.snap_id;
              state_nxt = S_SCAN_RD;
            end
            dfs_pkg::FUNC_RESET: begin
              count_nxt = '0;
              last_id_nxt = '0;
              in_sync_nxt = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      S_DMUL: begin
        if (mul_done) begin
          res_nxt.has_update = 1'b1;
          res_nxt.out_tag = 16'(TAG_BITS'(item_r.payload_tag));
          res_nxt.exchange_time_ns = mul_ns;
          res_nxt.out_recv_time_ns = item_r.recv_time_ns;
          last_id_nxt = item_r.upd_last;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_data_nxt = res_r;
          state_nxt = S_IDLE;
        end
      end
      S_SCAN_RD: begin
        if (idx_r == count_r) begin
          state_nxt = S_SN_EMIT;
        end else begin
          state_nxt = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        state_nxt = S_SCAN_RD;
        idx_nxt = idx_r + 1'b1;
        if (skipping_r) begin
          if ({1'b0, rd_final} > {1'b0, item_r.snap_id}) begin
            skipping_nxt = 1'b0;
            start_nxt = idx_r;
            through_nxt = rd_final;
            if ({1'b0, rd_first} > next_id || next_id > {1'b0, rd_final}) begin
              count_nxt = '0;
              res_nxt.verdict = 1'b1;
              state_nxt = S_EMIT;
            end
          end
        end else if ({1'b0, rd_first} != through_inc) begin
          count_nxt = '0;
          res_nxt.verdict = 1'b1;
          state_nxt = S_EMIT;
        end else begin
          through_nxt = rd_final;
        end
      end
      S_SN_EMIT: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_data_nxt = '0;
          out_data_nxt.has_update = 1'b1;
          out_data_nxt.snap_flag = 1'b1;
          out_data_nxt.out_tag = 16'(TAG_BITS'(item_r.payload_tag));
          out_data_nxt.out_recv_time_ns = item_r.recv_time_ns;
          idx_nxt = start_r;
          if (start_r == count_r) begin
            out_data_nxt.last_of_run = 1'b1;
            count_nxt = '0;
            last_id_nxt = through_r;
            in_sync_nxt = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_RP_RD;
          end
        end
      end
      S_RP_RD: begin
        state_nxt = S_RP_DAT;
      end
      S_RP_DAT: begin
        rp_tag_nxt = rd_tag;
        state_nxt = S_RP_MUL;
      end
      S_RP_MUL: begin
        if (mul_done) begin
          state_nxt = S_RP_EMIT;
        end
      end
      S_RP_EMIT: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_data_nxt = '0;
          out_data_nxt.has_update = 1'b1;
          out_data_nxt.out_tag = 16'(rp_tag_r);
          out_data_nxt.exchange_time_ns = mul_ns;
          out_data_nxt.out_recv_time_ns = item_r.recv_time_ns;
          idx_nxt = idx_r + 1'b1;
          if (idx_r + 1'b1 == count_r) begin
            out_data_nxt.last_of_run = 1'b1;
            count_nxt = '0;
            last_id_nxt = through_r;
            in_sync_nxt = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_RP_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers of the sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      last_id_r <= '0;
      in_sync_r <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r <= '0;
      start_r <= '0;
      skipping_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      last_id_r <= last_id_nxt;
      in_sync_r <= in_sync_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r <= idx_nxt;
      start_r <= start_nxt;
      skipping_r <= skipping_nxt;
    end
  end

  // Data registers carry no reset; they are only read once loaded.
  always_ff @(posedge clk) begin
    through_r <= through_nxt;
    item_r <= item_nxt;
    res_r <= res_nxt;
    rp_tag_r <= rp_tag_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  // The fill count never passes the buffer depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    7'(count_r) <= 7'(HOLD_DEPTH))
    else $error("held count beyond buffer depth");

  // A synced block holds nothing.
  a_sync_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_sync_r |-> count_r == '0)
    else $error("deltas held while synced");

  // A transfer without an update is a lone verdict with cleared fields.
  a_plain_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_data.has_update) |->
      (out_data.last_of_run && out_data.out_tag == '0
       && out_data.exchange_time_ns == '0 && !out_data.snap_flag))
    else $error("verdict-only transfer carries update fields");

endmodule
